[hw/rtl/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the multichannel moving average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

  // Field widths
  localparam int unsigned CH_W      = 3;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned REF_W     = 13;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SUM_W     = 22;
  localparam int unsigned PROD_W    = SAMPLE_W + REF_W;
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W);

  // Millivolt scaling divides by 2^SCALE_SHIFT - 1
  localparam int unsigned SCALE_SHIFT = 16;

  localparam logic [REF_W-1:0] REF_RESET = REF_W'(3300);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_MULT,
    ST_SCALE
  } mma_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic div_step;
    logic mult;
    logic emit;
  } mma_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ch_ok;
    logic div_done;
    logic out_free;
  } mma_status_t;

endpackage

`default_nettype wire

[hw/rtl/mma_if.sv]
// ----------------------------------------------------------------------------
// mma_in_if / mma_out_if
// Valid/ready channels for tagged samples and for averaged results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mma_in_if import mma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mma_out_if import mma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     out_channel;
  logic [SAMPLE_W-1:0] sample_mean;
  logic [REF_W-1:0]    average_millivolts;
  logic                window_filled;
  logic [COUNT_W-1:0]  channel_sample_total;

  modport source (output valid, output out_channel, output sample_mean,
                  output average_millivolts, output window_filled,
                  output channel_sample_total, input ready);
  modport sink   (input valid, input out_channel, input sample_mean,
                  input average_millivolts, input window_filled,
                  input channel_sample_total, output ready);
endinterface

`default_nettype wire

[hw/rtl/mma_ram.sv]
// ----------------------------------------------------------------------------
// mma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 60
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/mma_ctrl.sv]
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer: accepts a sample, walks it through ring read, state update,
// division, scaling, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ctrl import mma_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire mma_status_t status,
  output mma_cmd_t         cmd
);

  mma_state_t state;
  mma_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // drop out-of-range channels without leaving idle
        if (in_valid && status.ch_ok) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        // hold until the output register can take the beat
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/mma_dpath.sv]
// ----------------------------------------------------------------------------
// mma_dpath
// Per-channel state, sample ring, bit-serial divider, millivolt scaler
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_dpath import mma_pkg::*; #(
  parameter int unsigned CHANNELS = 6,
  parameter int unsigned WINDOW   = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mma_cmd_t            cmd,
  output mma_status_t              status,
  input  wire logic [CH_W-1:0]     in_channel,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                cfg_write,
  input  wire logic [REF_W-1:0]    cfg_data,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [CH_W-1:0]          out_channel,
  output logic [SAMPLE_W-1:0]      sample_mean,
  output logic [REF_W-1:0]         average_millivolts,
  output logic                     window_filled,
  output logic [COUNT_W-1:0]       channel_sample_total
);

  localparam int unsigned DEPTH = CHANNELS * WINDOW;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW    = $clog2(WINDOW);
  localparam int unsigned HW    = $clog2(WINDOW + 1);

  // Captured item and reference register
  logic [CH_W-1:0]     ch_reg;
  logic [SAMPLE_W-1:0] sample_reg;
  logic [REF_W-1:0]    ref_mv;

  // Per-channel state
  logic [SUM_W-1:0]   sum_arr  [CHANNELS];
  logic [PW-1:0]      pos_arr  [CHANNELS];
  logic               full_arr [CHANNELS];
  logic [COUNT_W-1:0] cnt_arr  [CHANNELS];

  // Result bookkeeping, divider and scaler
  logic                 res_full;
  logic [COUNT_W-1:0]   res_count;
  logic [HW-1:0]        divisor;
  logic [HW-1:0]        rem;
  logic [SUM_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PROD_W-1:0]    prod;

  logic [CW-1:0]       idx;
  logic [SUM_W-1:0]    cur_sum;
  logic [PW-1:0]       cur_pos;
  logic                cur_full;
  logic [COUNT_W-1:0]  cur_cnt;
  logic [AW-1:0]       ring_addr;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    sum_next;
  logic [PW-1:0]       pos_next;
  logic                full_next;
  logic [HW-1:0]       held;
  logic [HW:0]         trial;
  logic [HW:0]         diff;
  logic                take;
  logic [PROD_W:0]     scale_sum;
  logic [REF_W-1:0]    mv;

  // Look up the current channel
  assign idx      = ch_reg[CW-1:0];
  assign cur_sum  = sum_arr[idx];
  assign cur_pos  = pos_arr[idx];
  assign cur_full = full_arr[idx];
  assign cur_cnt  = cnt_arr[idx];

  assign ring_addr = AW'(ch_reg) * AW'(WINDOW) + AW'(cur_pos);

  mma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (ring_addr),
    .wdata (sample_reg),
    .raddr (ring_addr),
    .rdata (old_sample)
  );

  // Drop the oldest sample once the ring is full, add the new one
  always_comb begin
    if (cur_full) begin
      sum_next = cur_sum - SUM_W'(old_sample) + SUM_W'(sample_reg);
    end else begin
      sum_next = cur_sum + SUM_W'(sample_reg);
    end
    if (cur_pos == PW'(WINDOW - 1)) begin
      pos_next = '0;
    end else begin
      pos_next = cur_pos + PW'(1);
    end
    full_next = cur_full || (pos_next == '0);
    held      = full_next ? HW'(WINDOW) : HW'(pos_next);
  end

  // Restoring divider step
  assign trial = {rem, quo[SUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = (trial >= {1'b0, divisor});

  // Divide by 65535: exact for products below 2^32
  assign scale_sum = (PROD_W + 1)'(prod) + (PROD_W + 1)'(prod >> SCALE_SHIFT)
                   + (PROD_W + 1)'(1);
  assign mv        = REF_W'(scale_sum >> SCALE_SHIFT);

  assign status.ch_ok    = ({1'b0, in_channel} < (CH_W + 1)'(CHANNELS));
  assign status.div_done = (div_cnt == DIV_CNT_W'(SUM_W - 1));
  assign status.out_free = !out_valid || out_ready;

  // Reference register
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mv <= REF_RESET;
    end else if (cfg_write) begin
      ref_mv <= cfg_data;
    end
  end

  // Per-channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_arr[i]  <= '0;
        pos_arr[i]  <= '0;
        full_arr[i] <= 1'b0;
        cnt_arr[i]  <= '0;
      end
    end else if (cmd.update) begin
      sum_arr[idx]  <= sum_next;
      pos_arr[idx]  <= pos_next;
      full_arr[idx] <= full_next;
      cnt_arr[idx]  <= cur_cnt + COUNT_W'(1);
    end
  end

  // Capture, divide and multiply
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_reg     <= in_channel;
      sample_reg <= in_sample;
    end
    if (cmd.update) begin
      res_full  <= full_next;
      res_count <= cur_cnt + COUNT_W'(1);
      divisor   <= held;
      rem       <= '0;
      quo       <= sum_next;
      div_cnt   <= '0;
    end else if (cmd.div_step) begin
      rem     <= take ? diff[HW-1:0] : trial[HW-1:0];
      quo     <= {quo[SUM_W-2:0], take};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.mult) begin
      prod <= PROD_W'(quo[SAMPLE_W-1:0]) * PROD_W'(ref_mv);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_channel          <= ch_reg;
      sample_mean          <= quo[SAMPLE_W-1:0];
      average_millivolts   <= mv;
      window_filled        <= res_full;
      channel_sample_total <= res_count;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/multichannel_moving_average_unit.sv]
// ----------------------------------------------------------------------------
// multichannel_moving_average_unit
// Boxcar moving average over a window of samples per converter channel.
// ----------------------------------------------------------------------------
// Each beat on feed carries a channel number and a 16-bit sample. For an
// in-range channel the sample enters that channel's ring, the running sum
// drops the oldest sample once the ring is full, and one beat leaves on
// result with the truncated mean, the mean scaled to millivolts by
// cfg_data (reset 3300), the window-full flag and the channel's sample
// count. A channel at or above CHANNELS is taken and gives no beat. An
// in-range sample occupies the unit through acceptance, a ring read, an
// update, 22 steps of the bit-serial divider for the mean, a multiply
// and a scaling step. A finished result waits in the output register
// while the next sample is taken; the unit holds only if a second result
// is ready before the first has been taken.
// Write cfg_data only while the unit is idle.
`default_nettype none

module multichannel_moving_average_unit import mma_pkg::*; #(
  parameter int unsigned CHANNELS = 6,
  parameter int unsigned WINDOW   = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  mma_in_if.sink                feed,
  mma_out_if.source             result,
  input  wire logic             cfg_write,
  input  wire logic [REF_W-1:0] cfg_data
);

  mma_cmd_t    cmd;
  mma_status_t status;
  logic        in_ready;
  logic        out_valid;

  assign feed.ready   = in_ready;
  assign result.valid = out_valid;

  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mma_dpath #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_dpath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .in_channel           (feed.channel),
    .in_sample            (feed.sample),
    .cfg_write            (cfg_write),
    .cfg_data             (cfg_data),
    .out_ready            (result.ready),
    .out_valid            (out_valid),
    .out_channel          (result.out_channel),
    .sample_mean          (result.sample_mean),
    .average_millivolts   (result.average_millivolts),
    .window_filled        (result.window_filled),
    .channel_sample_total (result.channel_sample_total)
  );

  // A result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || result.ready))
    else $error("result loaded over an untaken beat");

  // A loaded result shows on the port in the next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("loaded result not presented");

  // An out-of-range channel leaves the unit ready
  a_drop_ready: assert property (@(posedge clk) disable iff (rst)
    (feed.valid && in_ready && ({1'b0, feed.channel} >= (CH_W + 1)'(CHANNELS)))
    |=> in_ready)
    else $error("dropped sample stalled the input");

  // An in-range sample starts processing and blocks further input
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (feed.valid && in_ready && ({1'b0, feed.channel} < (CH_W + 1)'(CHANNELS)))
    |=> !in_ready)
    else $error("input still open while a sample is processed");

endmodule

`default_nettype wire
